>>> sv/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg: shared constants for the ordered list table
// field widths, operation codes and the default list depth
// ----------------------------------------------------------------------------
package olt_pkg;

    // default number of list entries
    localparam int DEPTH_DEF = 64;

    // request and result field widths
    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 7;

    // packed stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT       = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE       = 3'd2;
    localparam logic [OP_W-1:0] OP_READ         = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR        = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd5;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

>>> sv/ordered_list_table.sv
// insert and remove move one entry at a time through the single read/write port
//   pair of the entry memory; a search compares one entry at a time
// throughput: one request at a time; the next is taken once the result has been taken
// reset: synchronous active-low reset empties the list; memory contents are not cleared
// ----------------------------------------------------------------------------
// ordered_list_table: ordered list of up to DEPTH 32-bit words
// append, insert, remove at index, read, clear and remove by value, each
// request giving one result with status, placement, read word and count
// ----------------------------------------------------------------------------
module ordered_list_table #(
    parameter int DEPTH = olt_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: position[6:0], word[38:7], zero pad[39]
    input  logic [olt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op[2:0]
    input  logic [olt_pkg::OP_W-1:0]       s_axis_tuser,
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: placed_at[6:0], read_word[38:7], count[45:39], zero pad[47:46]
    output logic [olt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[0]
    output logic                           m_axis_tuser
);
    import olt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam logic [LW-1:0] LEN_FULL = LW'(DEPTH);

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_UP_RD    = 10'b00_0000_0010,
        S_UP_WR    = 10'b00_0000_0100,
        S_DN_RD    = 10'b00_0000_1000,
        S_DN_WR    = 10'b00_0001_0000,
        S_FIND_RD  = 10'b00_0010_0000,
        S_FIND_CMP = 10'b00_0100_0000,
        S_READ_RD  = 10'b00_1000_0000,
        S_READ_CAP = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [LW-1:0]       r_len, n_len;
    logic [LW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_at, n_at;
    logic [WORD_W-1:0]   r_word, n_word;
    logic                r_status, n_status;
    logic [POS_W-1:0]    r_placed, n_placed;
    logic [WORD_W-1:0]   r_rdword, n_rdword;

    // entry memory, one write and one registered read per cycle
    logic [WORD_W-1:0]   r_mem [DEPTH];
    logic [WORD_W-1:0]   r_mem_q;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [WORD_W-1:0]   w_wdata;
    logic [AW-1:0]       w_raddr;

    // request fields
    logic [OP_W-1:0]     w_op;
    logic [POS_W-1:0]    w_pos;
    logic [WORD_W-1:0]   w_in_word;
    logic [CW-1:0]       w_pos_x;
    logic [CW-1:0]       w_len_x;
    logic [CW-1:0]       w_at_x;
    logic [CW-1:0]       w_cnt_x;
    logic [LW-1:0]       w_idx_m1;
    logic [LW-1:0]       w_idx_p1;
    logic                w_in_fire;

    assign w_op      = s_axis_tuser;
    assign w_pos     = s_axis_tdata[POS_W-1:0];
    assign w_in_word = s_axis_tdata[POS_W+WORD_W-1:POS_W];
    assign w_pos_x   = CW'(w_pos);
    assign w_len_x   = CW'(r_len);
    assign w_idx_m1  = r_idx - 1'b1;
    assign w_idx_p1  = r_idx + 1'b1;
    assign w_in_fire = s_axis_tvalid && s_axis_tready;

    // insert point, clamped to the end of the list; append always uses the end
    assign w_at_x = ((w_op == OP_APPEND) || (w_pos_x > w_len_x)) ? w_len_x : w_pos_x;

    // handshake and result packing
    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign w_cnt_x       = CW'(r_len);
    assign m_axis_tdata  = {2'b00, w_cnt_x[CNT_W-1:0], r_rdword, r_placed};
    assign m_axis_tuser  = r_status;

    // sequencer next state and memory port control
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_idx    = r_idx;
        n_at     = r_at;
        n_word   = r_word;
        n_status = r_status;
        n_placed = r_placed;
        n_rdword = r_rdword;
        w_we     = 1'b0;
        w_waddr  = r_at;
        w_wdata  = r_word;
        w_raddr  = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_status = STATUS_OK;
                    n_placed = '0;
                    n_rdword = '0;
                    n_state  = S_OUT;
                    unique case (w_op) inside
                        OP_APPEND, OP_INSERT: begin
                            if (r_len == LEN_FULL) begin
                                n_status = STATUS_ERR;
                            end else begin
                                n_at     = w_at_x[AW-1:0];
                                n_placed = w_at_x[POS_W-1:0];
                                n_idx    = r_len;
                                n_word   = w_in_word;
                                n_state  = S_UP_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (w_pos_x >= w_len_x) begin
                                n_status = STATUS_ERR;
                            end else begin
                                n_idx   = w_pos_x[LW-1:0];
                                n_state = S_DN_RD;
                            end
                        end
                        OP_READ: begin
                            if (w_pos_x >= w_len_x) begin
                                n_status = STATUS_ERR;
                            end else begin
                                n_idx   = w_pos_x[LW-1:0];
                                n_state = S_READ_RD;
                            end
                        end
                        OP_CLEAR: begin
                            n_len = '0;
                        end
                        OP_REMOVE_VALUE: begin
                            if (w_in_word == '0) begin
                                n_status = STATUS_ERR;
                            end else begin
                                n_idx   = '0;
                                n_word  = w_in_word;
                                n_state = S_FIND_RD;
                            end
                        end
                        default: begin
                            n_status = STATUS_ERR;
                        end
                    endcase
                end
            end
            // move entries up from the end down to the insert point, then place the word
            S_UP_RD: begin
                if (r_idx > LW'(r_at)) begin
                    w_raddr = w_idx_m1[AW-1:0];
                    n_state = S_UP_WR;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_at;
                    w_wdata = r_word;
                    n_len   = r_len + 1'b1;
                    n_state = S_OUT;
                end
            end
            S_UP_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = r_mem_q;
                n_idx   = w_idx_m1;
                n_state = S_UP_RD;
            end
            // move later entries down over the removed one
            S_DN_RD: begin
                if (w_idx_p1 < r_len) begin
                    w_raddr = w_idx_p1[AW-1:0];
                    n_state = S_DN_WR;
                end else begin
                    n_len   = r_len - 1'b1;
                    n_state = S_OUT;
                end
            end
            S_DN_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = r_mem_q;
                n_idx   = w_idx_p1;
                n_state = S_DN_RD;
            end
            // linear search for the first matching entry
            S_FIND_RD: begin
                if (r_idx < r_len) begin
                    w_raddr = r_idx[AW-1:0];
                    n_state = S_FIND_CMP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_FIND_CMP: begin
                if (r_mem_q == r_word) begin
                    n_state = S_DN_RD;
                end else begin
                    n_idx   = w_idx_p1;
                    n_state = S_FIND_RD;
                end
            end
            // indexed read
            S_READ_RD: begin
                w_raddr = r_idx[AW-1:0];
                n_state = S_READ_CAP;
            end
            S_READ_CAP: begin
                n_rdword = r_mem_q;
                n_state  = S_OUT;
            end
            // hold the result until taken
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_at     <= n_at;
        r_word   <= n_word;
        r_status <= n_status;
        r_placed <= n_placed;
        r_rdword <= n_rdword;
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_mem_q <= r_mem[w_raddr];
    end

    // list never grows past its depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_FULL)
        else $error("list length above depth");

    // no request is taken while a result is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request ready while result pending");

    // clear empties the list at once
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (w_op == OP_CLEAR)) |=> (r_len == '0))
        else $error("clear did not empty the list");

    // length moves by one entry or drops to zero
    a_len_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != $past(r_len)) |->
            ((r_len == $past(r_len) + 1'b1) || (r_len == $past(r_len) - 1'b1)
             || (r_len == '0)))
        else $error("length changed by more than one");

    // memory writes only happen while shifting or placing a word
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_UP_RD) || (r_state == S_UP_WR) || (r_state == S_DN_WR)))
        else $error("memory write outside a shift");

endmodule

>>> verif/tb_ordered_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_table: self-checking bench for the ordered list table
// drives append, insert, remove, read, clear, remove-by-value and undefined requests
// with random source and sink stalls, predicts each result from a shadow
// copy of the list and compares every result field by field
// ----------------------------------------------------------------------------
module tb_ordered_list_table;
    import olt_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int DEPTH      = DEPTH_DEF;
    localparam int MAX_IDLE   = 14;
    localparam int IDLE_LIMIT = 3000;
    localparam int TAIL_WAIT  = 4 * DEPTH + 8;

    // codes the block does not define
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    typedef enum int {MIX_BALANCED, MIX_GROW, MIX_SHRINK, MIX_SEARCH} t_phase_mix;

    typedef struct packed {
        logic              status;
        logic [POS_W-1:0]  placed_at;
        logic [WORD_W-1:0] read_word;
        logic [CNT_W-1:0]  count;
    } t_list_result;

    // shadow list and queue of results still owed by the block
    class t_list_shadow;
        logic [WORD_W-1:0] entries [DEPTH];
        int                used;
        t_list_result      owed [$];
        int                errors;
        int                n_requests;
        int                n_results;
        int                full_hits;
        int                peak_used;

        function new();
            used       = 0;
            errors     = 0;
            n_requests = 0;
            n_results  = 0;
            full_hits  = 0;
            peak_used  = 0;
        endfunction

        function void drop_entry(int at);
            int i;
            for (i = at; i + 1 < used; i++) begin
                entries[i] = entries[i + 1];
            end
            used--;
        endfunction

        // expected result of one request, updating the shadow list
        function t_list_result apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                             logic [WORD_W-1:0] w);
            t_list_result r;
            int           at;
            int           i;
            r = '0;
            case (op) inside
                OP_APPEND, OP_INSERT: begin
                    if (used >= DEPTH) begin
                        r.status = STATUS_ERR;
                        full_hits++;
                    end else begin
                        at = (op == OP_APPEND) ? used : int'(pos);
                        if (at > used) at = used;
                        for (i = used; i > at; i--) begin
                            entries[i] = entries[i - 1];
                        end
                        entries[at] = w;
                        used++;
                        r.placed_at = at[POS_W-1:0];
                    end
                end
                OP_REMOVE: begin
                    if (int'(pos) >= used) r.status = STATUS_ERR;
                    else drop_entry(int'(pos));
                end
                OP_READ: begin
                    if (int'(pos) < used) r.read_word = entries[pos];
                    else r.status = STATUS_ERR;
                end
                OP_CLEAR: begin
                    used = 0;
                end
                OP_REMOVE_VALUE: begin
                    if (w == '0) begin
                        r.status = STATUS_ERR;
                    end else begin
                        for (i = 0; i < used; i++) begin
                            if (entries[i] == w) begin
                                drop_entry(i);
                                break;
                            end
                        end
                    end
                end
                default: begin
                    r.status = STATUS_ERR;
                end
            endcase
            if (used > peak_used) peak_used = used;
            r.count = used[CNT_W-1:0];
            return r;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic [WORD_W-1:0] w);
            owed.push_back(apply_request(op, pos, w));
            n_requests++;
        endfunction

        function void flag(string field, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
            errors++;
            $error("%s: expected 'h%0h, actual 'h%0h", field, exp_v, act_v);
        endfunction

        function void check_result(t_list_result got);
            t_list_result want;
            n_results++;
            if (owed.size() == 0) begin
                errors++;
                $error("result with no request waiting");
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status)
                flag("status", WORD_W'(want.status), WORD_W'(got.status));
            if (got.placed_at !== want.placed_at)
                flag("placed_at", WORD_W'(want.placed_at), WORD_W'(got.placed_at));
            if (got.read_word !== want.read_word)
                flag("read_word", want.read_word, got.read_word);
            if (got.count !== want.count)
                flag("count", WORD_W'(want.count), WORD_W'(got.count));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    t_list_shadow sb;
    bit           send_calm;
    bit           take_calm;
    int           idle_cycles;

    ordered_list_table #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // one request: optional idle gap, then hold until taken; starts and ends at a falling edge
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] w);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {1'b0, w, pos};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, pos, w);
        @(negedge i_clk);
    endtask

    // hold off new requests until every owed result has come back
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // word choice: small pool for duplicates, words already stored, null, or anything
    function automatic logic [WORD_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return WORD_W'($urandom_range(1, 6));
        if (roll < 65 && sb.used > 0) return sb.entries[$urandom_range(0, sb.used - 1)];
        if (roll < 70) return '0;
        return $urandom;
    endfunction

    // position mostly around the current length, sometimes anywhere
    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 9) < 8) return POS_W'($urandom_range(0, sb.used));
        return POS_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [OP_W-1:0] pick_op(t_phase_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW: begin
                if (roll < 45) return OP_APPEND;
                if (roll < 85) return OP_INSERT;
                if (roll < 92) return OP_READ;
                if (roll < 96) return OP_REMOVE;
                return OP_REMOVE_VALUE;
            end
            MIX_SHRINK: begin
                if (roll < 10) return OP_APPEND;
                if (roll < 20) return OP_INSERT;
                if (roll < 55) return OP_REMOVE;
                if (roll < 70) return OP_READ;
                if (roll < 98) return OP_REMOVE_VALUE;
                return OP_CLEAR;
            end
            MIX_SEARCH: begin
                if (roll < 25) return OP_APPEND;
                if (roll < 35) return OP_INSERT;
                if (roll < 40) return OP_REMOVE;
                if (roll < 50) return OP_READ;
                return OP_REMOVE_VALUE;
            end
            default: begin
                if (roll < 20) return OP_APPEND;
                if (roll < 40) return OP_INSERT;
                if (roll < 55) return OP_REMOVE;
                if (roll < 75) return OP_READ;
                if (roll < 77) return OP_CLEAR;
                if (roll < 95) return OP_REMOVE_VALUE;
                return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
            end
        endcase
    endfunction

    task automatic run_phase(input t_phase_mix mix, input int n, input bit calm);
        send_calm = calm;
        take_calm = calm;
        repeat (n) send_request(pick_op(mix), pick_pos(), pick_word());
        wait_drained();
        send_calm = 1'b0;
        take_calm = 1'b0;
    endtask

    // result sink with random stalls, some of them while a result is waiting
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = take_calm ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                if ($urandom_range(0, 1) == 1) begin
                    do @(posedge i_clk); while (!m_axis_tvalid);
                    @(negedge i_clk);
                end
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result({m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[38:7],
                             m_axis_tdata[45:39]});
            @(negedge i_clk);
        end
    end

    // watchdog on cycles with no request or result moving
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        sb            = new();
        send_calm     = 1'b0;
        take_calm     = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_APPEND;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty list: out of range, null search, absent value
        send_request(OP_READ, 7'd0, 32'h0);
        send_request(OP_REMOVE, 7'd0, 32'h0);
        send_request(OP_REMOVE_VALUE, 7'd0, 32'h0);
        send_request(OP_REMOVE_VALUE, 7'd0, 32'h0000_1234);
        // word extremes, insert at front, insert past end, insert in middle
        send_request(OP_APPEND, 7'd0, 32'hFFFF_FFFF);
        send_request(OP_APPEND, 7'd127, 32'h0000_0000);
        send_request(OP_INSERT, 7'd0, 32'hA5A5_A5A5);
        send_request(OP_INSERT, 7'd127, 32'h5A5A_5A5A);
        send_request(OP_INSERT, 7'd2, 32'h0000_0001);
        // reads in and out of range
        send_request(OP_READ, 7'd0, 32'h0);
        send_request(OP_READ, 7'd4, 32'hFFFF_FFFF);
        send_request(OP_READ, 7'd5, 32'h0);
        send_request(OP_READ, 7'd127, 32'h0);
        // removes by index and by value
        send_request(OP_REMOVE, 7'd127, 32'h0);
        send_request(OP_REMOVE, 7'd1, 32'h0);
        send_request(OP_REMOVE_VALUE, 7'd0, 32'hFFFF_FFFF);
        send_request(OP_REMOVE_VALUE, 7'd3, 32'h8000_0000);
        // undefined codes
        send_request(OP_UNDEF_LO, 7'd0, 32'h0);
        send_request(OP_UNDEF_HI, 7'd127, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 7'd0, 32'h0);
        // clear, clear on empty, restart
        send_request(OP_CLEAR, 7'd0, 32'h0);
        send_request(OP_CLEAR, 7'd127, 32'hFFFF_FFFF);
        send_request(OP_APPEND, 7'd0, 32'h8000_0000);
        send_request(OP_READ, 7'd0, 32'h0);
        wait_drained();

        // fill to the limit, then grow on a full list
        while (sb.used < DEPTH) begin
            if ($urandom_range(0, 1) == 1) send_request(OP_APPEND, pick_pos(), $urandom);
            else send_request(OP_INSERT, pick_pos(), $urandom);
        end
        send_request(OP_APPEND, 7'd0, $urandom);
        send_request(OP_INSERT, 7'd0, $urandom);
        send_request(OP_READ, 7'd63, 32'h0);
        send_request(OP_REMOVE, 7'd63, 32'h0);
        wait_drained();

        // random phases, drained between each
        run_phase(MIX_BALANCED, 220, 1'b0);
        run_phase(MIX_GROW, 220, 1'b0);
        run_phase(MIX_SEARCH, 220, 1'b0);
        run_phase(MIX_SHRINK, 220, 1'b0);
        run_phase(MIX_GROW, 200, 1'b1);
        run_phase(MIX_BALANCED, 220, 1'b1);
        run_phase(MIX_SEARCH, 220, 1'b0);
        run_phase(MIX_SHRINK, 200, 1'b0);
        run_phase(MIX_BALANCED, 60, 1'b0);

        // let any stray result show up
        s_axis_tvalid = 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("covered %0d requests and %0d results, all six operations and undefined codes",
                 sb.n_requests, sb.n_results);
        $display("list peaked at %0d entries with %0d full-list rejections, %0d mismatches",
                 sb.peak_used, sb.full_hits, sb.errors);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
